[rtl/core/keyed_delay_statistics_macros.svh]
// Assertion helpers for the keyed delay statistics block.
`ifndef KEYED_DELAY_STATISTICS_MACROS_SVH
`define KEYED_DELAY_STATISTICS_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KDS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kds: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define KDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kds: next-cycle check failed");

`endif

[rtl/core/kds_pkg.sv]
package kds_pkg;

   localparam int TABLE_DEPTH_DEF = 32;
   localparam int KEY_W           = 32;
   localparam int STAT_W          = 64;

   localparam logic [STAT_W-1:0] ALL_ONES = '1;

   // request beat payload, start_time in the lowest bits
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [STAT_W-1:0] end_time;
      logic [STAT_W-1:0] start_time;
   } req_data_type;

   localparam int REQ_DATA_W = $bits(req_data_type);

   // one table entry, also the response payload; key in the lowest bits
   typedef struct packed {
      logic [STAT_W-1:0] max;
      logic [STAT_W-1:0] min;
      logic [STAT_W-1:0] sum;
      logic [STAT_W-1:0] count;
      logic [KEY_W-1:0]  key;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic {
      OP_RECORD = 1'b0,
      OP_REPORT = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DELTA,
      ST_SCAN,
      ST_PICK,
      ST_UPDATE,
      ST_RSCAN,
      ST_RNEXT,
      ST_TREPORT
   } state_type;

   // statistic update steps run through the shared adder
   typedef enum logic [1:0] {
      STEP_MIN,
      STEP_MAX,
      STEP_SUM,
      STEP_COUNT
   } step_type;

endpackage

[rtl/core/kds_ram.sv]
module kds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/keyed_delay_statistics.sv]
// Keyed delay statistics.
// req_* carries one beat per command: tuser 0 records a start/end pair,
// tuser 1 asks for a report. A record whose end is later than its start
// adds the delay to the global total and, in per-key mode, to the entry
// of its key in a TABLE_DEPTH-entry RAM. A report returns beats on rsp_*,
// tlast on the final one: the total (total mode) or every entry with
// samples in ascending key order (per-key mode); reported values are
// cleared. A report with nothing to show returns no beat.
// A record first subtracts start from end in the shared adder; in total
// mode it then runs four adder steps on the total, in per-key mode a key
// scan (one RAM read per entry) and four adder steps each for entry and
// total (total only when the table is full). It stops after the subtract
// when end is not after start. A per-key report makes one full scan per
// entry to find the next smallest key. req_tready is high only between
// commands. A finished beat sits in an output register, so a stalled
// receiver only holds the block once a second beat is ready.
// Reset (synchronous) clears the table's valid bits and the total at once;
// there is no clearing pass. csr_we writes per_key_mode from csr_wdata.
`include "keyed_delay_statistics_macros.svh"

module keyed_delay_statistics #(
   parameter int TABLE_DEPTH = kds_pkg::TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request: tdata = start_time, end_time, key; tuser = opcode
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [kds_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tuser,
   // response: tdata = entry_key, sample_count, delay_sum, delay_min,
   // delay_max; tlast = last_of_report
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [kds_pkg::ENTRY_W-1:0]    rsp_tdata,
   output logic                           rsp_tlast,
   // per_key_mode register
   input  logic                           csr_we,
   input  logic                           csr_wdata
);
   import kds_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   req_data_type             req_d;
   entry_type                rd_e;
   logic [ENTRY_W-1:0]       ram_rdata;

   state_type                state_ff, state_in;
   step_type                 step_ff, step_in;
   logic                     mode_ff, mode_in;
   logic [KEY_W-1:0]         key_ff, key_in;
   logic [STAT_W-1:0]        start_ff, start_in;
   logic [STAT_W-1:0]        end_ff, end_in;
   logic [STAT_W-1:0]        d_ff, d_in;
   logic                     tgt_slot_ff, tgt_slot_in;
   logic [IDX_W-1:0]         slot_idx_ff, slot_idx_in;
   logic [CNT_W-1:0]         scan_idx_ff, scan_idx_in;
   logic                     rd_live_ff, rd_live_in;
   logic [IDX_W-1:0]         rd_idx_ff, rd_idx_in;
   logic                     hit_ff, hit_in;
   logic                     spare_ff, spare_in;
   logic [IDX_W-1:0]         spare_idx_ff, spare_idx_in;
   logic [KEY_W-1:0]         best_key_ff, best_key_in;
   logic [STAT_W-1:0]        w_cnt_ff, w_cnt_in;
   logic [STAT_W-1:0]        w_sum_ff, w_sum_in;
   logic [STAT_W-1:0]        w_min_ff, w_min_in;
   logic [STAT_W-1:0]        w_max_ff, w_max_in;
   logic [STAT_W-1:0]        tot_cnt_ff, tot_cnt_in;
   logic [STAT_W-1:0]        tot_sum_ff, tot_sum_in;
   logic [STAT_W-1:0]        tot_min_ff, tot_min_in;
   logic [STAT_W-1:0]        tot_max_ff, tot_max_in;
   logic [TABLE_DEPTH-1:0]   valid_ff, valid_in;
   logic [TABLE_DEPTH-1:0]   emit_ff, emit_in;
   logic                     pend_ff, pend_in;
   entry_type                pend_data_ff, pend_data_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   entry_type                rsp_data_ff, rsp_data_in;
   logic                     rsp_last_ff, rsp_last_in;

   // shared adder / comparator
   logic [STAT_W-1:0]        alu_a, alu_b, alu_res;
   logic                     alu_sub, alu_carry, alu_lt;

   logic                     scan_issue;
   logic                     rsp_free;
   logic                     push, push_last;
   entry_type                push_data;
   logic                     ram_we;
   logic [IDX_W-1:0]         ram_waddr;
   entry_type                ram_wdata;

   assign req_d = req_data_type'(req_tdata);
   assign rd_e  = entry_type'(ram_rdata);

   kds_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (scan_issue),
      .rd_addr (scan_idx_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   // operand select for the shared unit
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      unique case (state_ff)
         ST_DELTA: begin
            alu_a   = end_ff;
            alu_b   = start_ff;
            alu_sub = 1'b1;
         end
         ST_UPDATE: begin
            unique case (step_ff)
               STEP_MIN: begin
                  alu_a   = d_ff;
                  alu_b   = w_min_ff;
                  alu_sub = 1'b1;
               end
               STEP_MAX: begin
                  alu_a   = w_max_ff;
                  alu_b   = d_ff;
                  alu_sub = 1'b1;
               end
               STEP_SUM: begin
                  alu_a = w_sum_ff;
                  alu_b = d_ff;
               end
               STEP_COUNT: begin
                  alu_a = w_cnt_ff;
                  alu_b = STAT_W'(1);
               end
            endcase
         end
         ST_RSCAN: begin
            alu_a   = {{(STAT_W - KEY_W){1'b0}}, rd_e.key};
            alu_b   = {{(STAT_W - KEY_W){1'b0}}, best_key_ff};
            alu_sub = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign {alu_carry, alu_res} = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                               + {{STAT_W{1'b0}}, alu_sub};
   // borrow on subtract: a < b
   assign alu_lt = ~alu_carry;

   // sequencer: next state and datapath
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      mode_in      = csr_we ? csr_wdata : mode_ff;
      key_in       = key_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      d_in         = d_ff;
      tgt_slot_in  = tgt_slot_ff;
      slot_idx_in  = slot_idx_ff;
      hit_in       = hit_ff;
      spare_in     = spare_ff;
      spare_idx_in = spare_idx_ff;
      best_key_in  = best_key_ff;
      w_cnt_in     = w_cnt_ff;
      w_sum_in     = w_sum_ff;
      w_min_in     = w_min_ff;
      w_max_in     = w_max_ff;
      tot_cnt_in   = tot_cnt_ff;
      tot_sum_in   = tot_sum_ff;
      tot_min_in   = tot_min_ff;
      tot_max_in   = tot_max_ff;
      valid_in     = valid_ff;
      emit_in      = emit_ff;
      pend_in      = pend_ff;
      pend_data_in = pend_data_ff;
      push         = 1'b0;
      push_last    = 1'b0;
      push_data    = pend_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = slot_idx_ff;
      ram_wdata    = '{max: w_max_ff, min: w_min_ff, sum: w_sum_ff,
                       count: alu_res, key: key_ff};
      rsp_free     = ~rsp_valid_ff | rsp_tready;
      req_tready   = (state_ff == ST_IDLE);

      // table scan: one read issued per cycle, data checked in the next cycle
      scan_issue  = ((state_ff == ST_SCAN) || (state_ff == ST_RSCAN)) &&
                    (scan_idx_ff < SCAN_END);
      scan_idx_in = scan_issue ? scan_idx_ff + CNT_W'(1) : scan_idx_ff;
      rd_live_in  = scan_issue;
      rd_idx_in   = scan_idx_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               key_in   = req_d.key;
               start_in = req_d.start_time;
               end_in   = req_d.end_time;
               if (opcode_type'(req_tuser) == OP_RECORD) begin
                  state_in = ST_DELTA;
               end else if (mode_ff) begin
                  emit_in     = '0;
                  pend_in     = 1'b0;
                  hit_in      = 1'b0;
                  scan_idx_in = '0;
                  state_in    = ST_RSCAN;
               end else begin
                  state_in = ST_TREPORT;
               end
            end
         end

         ST_DELTA: begin
            d_in = alu_res;
            if (!(alu_carry && (alu_res != '0))) begin
               state_in = ST_IDLE;
            end else if (mode_ff) begin
               hit_in      = 1'b0;
               spare_in    = 1'b0;
               scan_idx_in = '0;
               state_in    = ST_SCAN;
            end else begin
               w_cnt_in    = tot_cnt_ff;
               w_sum_in    = tot_sum_ff;
               w_min_in    = tot_min_ff;
               w_max_in    = tot_max_ff;
               tgt_slot_in = 1'b0;
               step_in     = STEP_MIN;
               state_in    = ST_UPDATE;
            end
         end

         // look for the key and the lowest free slot
         ST_SCAN: begin
            if (rd_live_ff) begin
               if (valid_ff[rd_idx_ff] && (rd_e.key == key_ff) && !hit_ff) begin
                  hit_in      = 1'b1;
                  slot_idx_in = rd_idx_ff;
                  w_cnt_in    = rd_e.count;
                  w_sum_in    = rd_e.sum;
                  w_min_in    = rd_e.min;
                  w_max_in    = rd_e.max;
               end
               if (!valid_ff[rd_idx_ff] && !spare_ff) begin
                  spare_in     = 1'b1;
                  spare_idx_in = rd_idx_ff;
               end
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = ST_PICK;
               end
            end
         end

         ST_PICK: begin
            step_in  = STEP_MIN;
            state_in = ST_UPDATE;
            if (hit_ff) begin
               tgt_slot_in = 1'b1;
            end else if (spare_ff) begin
               tgt_slot_in            = 1'b1;
               slot_idx_in            = spare_idx_ff;
               valid_in[spare_idx_ff] = 1'b1;
               w_cnt_in               = '0;
               w_sum_in               = '0;
               w_min_in               = ALL_ONES;
               w_max_in               = '0;
            end else begin
               // table full: only the total takes the sample
               tgt_slot_in = 1'b0;
               w_cnt_in    = tot_cnt_ff;
               w_sum_in    = tot_sum_ff;
               w_min_in    = tot_min_ff;
               w_max_in    = tot_max_ff;
            end
         end

         ST_UPDATE: begin
            unique case (step_ff)
               STEP_MIN: begin
                  if (alu_lt) begin
                     w_min_in = d_ff;
                  end
                  step_in = STEP_MAX;
               end
               STEP_MAX: begin
                  if (alu_lt) begin
                     w_max_in = d_ff;
                  end
                  step_in = STEP_SUM;
               end
               STEP_SUM: begin
                  w_sum_in = alu_res;
                  step_in  = STEP_COUNT;
               end
               STEP_COUNT: begin
                  if (tgt_slot_ff) begin
                     // write back the entry, then run the total
                     ram_we      = 1'b1;
                     w_cnt_in    = tot_cnt_ff;
                     w_sum_in    = tot_sum_ff;
                     w_min_in    = tot_min_ff;
                     w_max_in    = tot_max_ff;
                     tgt_slot_in = 1'b0;
                     step_in     = STEP_MIN;
                  end else begin
                     tot_cnt_in = alu_res;
                     tot_sum_in = w_sum_ff;
                     tot_min_in = w_min_ff;
                     tot_max_in = w_max_ff;
                     state_in   = ST_IDLE;
                  end
               end
            endcase
         end

         // drop empty entries, find the smallest key not yet reported
         ST_RSCAN: begin
            if (rd_live_ff) begin
               if (valid_ff[rd_idx_ff] && !emit_ff[rd_idx_ff]) begin
                  if (rd_e.count == '0) begin
                     valid_in[rd_idx_ff] = 1'b0;
                  end else if (!hit_ff || alu_lt) begin
                     hit_in      = 1'b1;
                     slot_idx_in = rd_idx_ff;
                     best_key_in = rd_e.key;
                     w_cnt_in    = rd_e.count;
                     w_sum_in    = rd_e.sum;
                     w_min_in    = rd_e.min;
                     w_max_in    = rd_e.max;
                  end
               end
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = ST_RNEXT;
               end
            end
         end

         // one beat is held back until we know whether it is the last
         ST_RNEXT: begin
            if (hit_ff) begin
               if (!pend_ff || rsp_free) begin
                  push                 = pend_ff;
                  pend_in              = 1'b1;
                  pend_data_in         = '{max: w_max_ff, min: w_min_ff, sum: w_sum_ff,
                                           count: w_cnt_ff, key: best_key_ff};
                  ram_we               = 1'b1;
                  ram_wdata            = '{max: '0, min: ALL_ONES, sum: '0,
                                           count: '0, key: best_key_ff};
                  emit_in[slot_idx_ff] = 1'b1;
                  hit_in               = 1'b0;
                  scan_idx_in          = '0;
                  state_in             = ST_RSCAN;
               end
            end else if (!pend_ff) begin
               state_in = ST_IDLE;
            end else if (rsp_free) begin
               push      = 1'b1;
               push_last = 1'b1;
               pend_in   = 1'b0;
               state_in  = ST_IDLE;
            end
         end

         ST_TREPORT: begin
            if (tot_cnt_ff == '0) begin
               state_in = ST_IDLE;
            end else if (rsp_free) begin
               push       = 1'b1;
               push_last  = 1'b1;
               push_data  = '{max: tot_max_ff, min: tot_min_ff, sum: tot_sum_ff,
                              count: tot_cnt_ff, key: '0};
               tot_cnt_in = '0;
               tot_sum_in = '0;
               tot_min_in = ALL_ONES;
               tot_max_in = '0;
               state_in   = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // output register
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = push_data;
         rsp_last_in  = push_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_MIN;
         mode_ff      <= 1'b0;
         tgt_slot_ff  <= 1'b0;
         scan_idx_ff  <= '0;
         rd_live_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         spare_ff     <= 1'b0;
         valid_ff     <= '0;
         emit_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tot_cnt_ff   <= '0;
         tot_sum_ff   <= '0;
         tot_min_ff   <= ALL_ONES;
         tot_max_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         mode_ff      <= mode_in;
         tgt_slot_ff  <= tgt_slot_in;
         scan_idx_ff  <= scan_idx_in;
         rd_live_ff   <= rd_live_in;
         hit_ff       <= hit_in;
         spare_ff     <= spare_in;
         valid_ff     <= valid_in;
         emit_ff      <= emit_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         tot_cnt_ff   <= tot_cnt_in;
         tot_sum_ff   <= tot_sum_in;
         tot_min_ff   <= tot_min_in;
         tot_max_ff   <= tot_max_in;
      end
      key_ff       <= key_in;
      start_ff     <= start_in;
      end_ff       <= end_in;
      d_ff         <= d_in;
      slot_idx_ff  <= slot_idx_in;
      rd_idx_ff    <= rd_idx_in;
      spare_idx_ff <= spare_idx_in;
      best_key_ff  <= best_key_in;
      w_cnt_ff     <= w_cnt_in;
      w_sum_ff     <= w_sum_in;
      w_min_ff     <= w_min_in;
      w_max_ff     <= w_max_in;
      pend_data_ff <= pend_data_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   `KDS_ASSERT_IMPLY(a_push_no_overwrite, clock, reset, push, rsp_free)
   `KDS_ASSERT_IMPLY(a_no_write_in_scan, clock, reset, ram_we,
                     !((state_ff == ST_SCAN) || (state_ff == ST_RSCAN)))
   `KDS_ASSERT_IMPLY(a_write_valid_slot, clock, reset, ram_we && (state_ff == ST_UPDATE),
                     valid_ff[slot_idx_ff])
   `KDS_ASSERT_NEXT(a_insert_sets_valid, clock, reset,
                    (state_ff == ST_PICK) && !hit_ff && spare_ff, valid_ff[slot_idx_ff])

endmodule
